FILE: rtl/jpeg_marker_segment_scanner_top_assert.svh
// Assertion macros used by the checker of the JPEG marker segment scanner.
`ifndef JPEG_MARKER_SEGMENT_SCANNER_TOP_ASSERT_SVH
`define JPEG_MARKER_SEGMENT_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JMSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("jmss assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define JMSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("jmss assertion failed");

`endif

FILE: rtl/jmss_pkg.sv
// Types, codes and helper functions of the JPEG marker segment scanner.
`default_nettype none

package jmss_pkg;

	localparam int OFFSET_BITS_DEFAULT = 32;

	// Result event codes.
	localparam logic [2:0] EV_MARKER  = 3'd0;
	localparam logic [2:0] EV_EXIF    = 3'd1;
	localparam logic [2:0] EV_OK      = 3'd2;
	localparam logic [2:0] EV_INVALID = 3'd3;
	localparam logic [2:0] EV_LENERR  = 3'd4;

	// Marker bytes.
	localparam logic [7:0] BYTE_FF   = 8'hFF;
	localparam logic [7:0] BYTE_00   = 8'h00;
	localparam logic [7:0] MRK_SOI   = 8'hD8;
	localparam logic [7:0] MRK_EOI   = 8'hD9;
	localparam logic [7:0] MRK_APP1  = 8'hE1;
	localparam logic [7:0] MRK_RST0  = 8'hD0;
	localparam logic [7:0] MRK_SOS   = 8'hDA;

	localparam logic [2:0] EXIF_TAG_LEN = 3'd6;

	typedef enum logic [10:0] {
		PH_IDLE  = 11'b000_0000_0001,
		PH_SOI0  = 11'b000_0000_0010,
		PH_SOI1  = 11'b000_0000_0100,
		PH_MARK0 = 11'b000_0000_1000,
		PH_MARK1 = 11'b000_0001_0000,
		PH_LEN0  = 11'b000_0010_0000,
		PH_LEN1  = 11'b000_0100_0000,
		PH_SKIP  = 11'b000_1000_0000,
		PH_EXIF  = 11'b001_0000_0000,
		PH_ENT   = 11'b010_0000_0000,
		PH_ENTFF = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic       image_start;
		logic [7:0] byte_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  marker_code;
		logic [31:0] byte_offset;
		logic [15:0] segment_length;
		logic        last;
	} out_item_t;

	// Status reported when the file ends while the parser sits in a given phase.
	function automatic logic [2:0] end_status(input phase_t ph);
		logic [2:0] ev;
		case (ph)
			PH_MARK0, PH_SKIP, PH_EXIF, PH_ENT: ev = EV_OK;
			default:                            ev = EV_INVALID;
		endcase
		return ev;
	endfunction

	// The six bytes of the Exif header: "Exif" and two zero bytes.
	function automatic logic [7:0] exif_tag(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = 8'h45;
			3'd1:    b = 8'h78;
			3'd2:    b = 8'h69;
			3'd3:    b = 8'h66;
			default: b = BYTE_00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/jpeg_marker_segment_scanner_top.sv
// Top level of the JPEG marker segment scanner: byte parser and output queue.
// The scanner takes one file byte per beat and can accept a byte on every clock.
// Each byte is decoded by combinational logic against the registered parser state,
// and the results it causes, none, one or two, are written into a four-entry output
// queue in the same clock. The output channel drains one result per beat.
// The input stalls while the queue holds more than two results, so one byte per
// clock is kept up as long as the consumer takes one result per clock; a byte
// that ends the parse may add a second result and costs one extra output beat.
// Write file_length before the first byte of a file; a byte with image_start
// set restarts the parse at file offset zero.
`default_nettype none

module jpeg_marker_segment_scanner_top #(
	parameter int OFFSET_BITS = jmss_pkg::OFFSET_BITS_DEFAULT
) (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic in_valid,
	output                     logic in_stall,
	input  wire jmss_pkg::in_item_t  in_data,
	output                     logic out_valid,
	input  wire                logic out_stall,
	output jmss_pkg::out_item_t      out_data,
	input  wire                logic cfg_valid,
	output                     logic cfg_ready,
	input  wire         logic [31:0] cfg_data
);

	localparam int CW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	// Parser state.
	jmss_pkg::phase_t        phase_q;
	logic [OFFSET_BITS-1:0]  bytes_seen_q;
	logic [7:0]              cur_marker_q;
	logic [15:0]             length_field_q;
	logic [15:0]             skip_rem_q;
	logic [2:0]              match_idx_q;
	logic                    finished_q;
	logic [31:0]             file_length_q;

	// Output queue.
	jmss_pkg::out_item_t     queue_q [QDEPTH];
	logic [QAW-1:0]          wr_ptr_q;
	logic [QAW-1:0]          rd_ptr_q;
	logic [QAW:0]            count_q;

	// Next-state values.
	jmss_pkg::phase_t        ph;
	logic [OFFSET_BITS-1:0]  bs;
	logic [7:0]              cm;
	logic [15:0]             lf;
	logic [15:0]             sk;
	logic [15:0]             seg_len;
	logic [2:0]              hmi;
	logic                    fin;
	logic [31:0]             pos32;
	logic [7:0]              b;
	jmss_pkg::out_item_t     rs [2];
	logic [1:0]              n_res;

	logic                    in_acc;
	logic                    out_acc;

	function automatic logic [31:0] off32(input logic [OFFSET_BITS-1:0] v);
		logic [CW-1:0] ext;
		ext = CW'(v);
		return ext[31:0];
	endfunction

	function automatic logic at_end(input logic [OFFSET_BITS-1:0] v, input logic [31:0] fl);
		return CW'(v) >= CW'(fl);
	endfunction

	function automatic jmss_pkg::out_item_t mk(input logic [2:0] ev, input logic [7:0] mc,
			input logic [31:0] off, input logic [15:0] len, input logic lst);
		jmss_pkg::out_item_t r;
		r.event_res      = ev;
		r.marker_code    = mc;
		r.byte_offset    = off;
		r.segment_length = len;
		r.last           = lst;
		return r;
	endfunction

	assign in_stall  = (count_q > (QAW+1)'(QDEPTH - 2));
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (count_q != '0);
	assign out_acc   = out_valid && !out_stall;
	assign out_data  = queue_q[rd_ptr_q];
	assign cfg_ready = 1'b1;
	assign b         = in_data.byte_value;

	// Decode of one byte. Results are collected in order in rs, n_res counts them.
	always_comb begin
		ph      = phase_q;
		bs      = bytes_seen_q;
		cm      = cur_marker_q;
		lf      = length_field_q;
		sk      = skip_rem_q;
		hmi     = match_idx_q;
		fin     = finished_q;
		pos32   = off32(bytes_seen_q);
		seg_len = '0;
		rs[0]   = '0;
		rs[1]   = '0;
		n_res   = 2'd0;

		if (in_data.image_start) begin
			ph  = jmss_pkg::PH_SOI0;
			bs  = '0;
			cm  = '0;
			lf  = '0;
			sk  = '0;
			hmi = '0;
			fin = 1'b0;
		end

		if (!fin) begin
			if (at_end(bs, file_length_q)) begin
				// Byte arrives past the end of the file and is not consumed.
				rs[n_res[0]] = mk(jmss_pkg::end_status(ph), cm, off32(bs), lf, 1'b1);
				n_res = n_res + 2'd1;
				fin = 1'b1;
				ph  = jmss_pkg::PH_IDLE;
			end else begin
				pos32 = off32(bs);
				if (bs != '1) begin
					bs = bs + 1'b1;
				end

				case (ph)
					jmss_pkg::PH_SOI0: begin
						if (b == jmss_pkg::BYTE_FF) begin
							ph = jmss_pkg::PH_SOI1;
						end else begin
							rs[n_res[0]] = mk(jmss_pkg::EV_INVALID, cm, off32(bs), lf, 1'b1);
							n_res = n_res + 2'd1;
							fin = 1'b1;
						end
					end
					jmss_pkg::PH_SOI1: begin
						if (b == jmss_pkg::MRK_SOI) begin
							cm = jmss_pkg::MRK_SOI;
							rs[n_res[0]] = mk(jmss_pkg::EV_MARKER, cm, pos32 - 32'd1, 16'd0, 1'b0);
							n_res = n_res + 2'd1;
							ph = jmss_pkg::PH_MARK0;
						end else begin
							rs[n_res[0]] = mk(jmss_pkg::EV_INVALID, cm, off32(bs), lf, 1'b1);
							n_res = n_res + 2'd1;
							fin = 1'b1;
						end
					end
					jmss_pkg::PH_MARK0: begin
						if (b == jmss_pkg::BYTE_FF) begin
							ph = jmss_pkg::PH_MARK1;
						end else begin
							rs[n_res[0]] = mk(jmss_pkg::EV_INVALID, cm, off32(bs), lf, 1'b1);
							n_res = n_res + 2'd1;
							fin = 1'b1;
						end
					end
					jmss_pkg::PH_MARK1, jmss_pkg::PH_ENTFF: begin
						if (ph == jmss_pkg::PH_ENTFF && b == jmss_pkg::BYTE_00) begin
							// Stuffed zero after FF inside entropy-coded data.
							ph = jmss_pkg::PH_ENT;
						end else begin
							cm = b;
							lf = '0;
							if (b == jmss_pkg::BYTE_FF || b == jmss_pkg::MRK_SOI) begin
								rs[n_res[0]] = mk(jmss_pkg::EV_INVALID, cm, off32(bs), lf, 1'b1);
								n_res = n_res + 2'd1;
								fin = 1'b1;
							end else if (b == jmss_pkg::BYTE_00) begin
								rs[n_res[0]] = mk(jmss_pkg::EV_OK, cm, off32(bs), lf, 1'b1);
								n_res = n_res + 2'd1;
								fin = 1'b1;
							end else if (b == jmss_pkg::MRK_EOI) begin
								rs[0] = mk(jmss_pkg::EV_MARKER, cm, pos32 - 32'd1, 16'd0, 1'b0);
								rs[1] = mk(jmss_pkg::EV_OK, cm, off32(bs), lf, 1'b1);
								n_res = 2'd2;
								fin = 1'b1;
							end else if (b inside {[jmss_pkg::MRK_RST0:jmss_pkg::MRK_SOS]}) begin
								rs[n_res[0]] = mk(jmss_pkg::EV_MARKER, cm, pos32 - 32'd1, 16'd0, 1'b0);
								n_res = n_res + 2'd1;
								ph = jmss_pkg::PH_ENT;
							end else begin
								ph = jmss_pkg::PH_LEN0;
							end
						end
					end
					jmss_pkg::PH_LEN0: begin
						lf = {b, 8'h00};
						ph = jmss_pkg::PH_LEN1;
					end
					jmss_pkg::PH_LEN1: begin
						lf = {lf[15:8], b};
						rs[0] = mk(jmss_pkg::EV_MARKER, cm, pos32 - 32'd3, lf, 1'b0);
						n_res = 2'd1;
						if (cm == jmss_pkg::MRK_APP1) begin
							if ({16'd0, lf} > file_length_q) begin
								rs[1] = mk(jmss_pkg::EV_LENERR, cm, off32(bs), lf, 1'b1);
								n_res = 2'd2;
								fin = 1'b1;
							end else if (lf <= 16'd7) begin
								rs[1] = mk(jmss_pkg::EV_OK, cm, off32(bs), lf, 1'b1);
								n_res = 2'd2;
								fin = 1'b1;
							end else begin
								hmi = '0;
								ph  = jmss_pkg::PH_EXIF;
							end
						end else begin
							// Lengths 0 and 1 are taken as raw skip counts.
							seg_len = (lf > 16'd1) ? (lf - 16'd2) : lf;
							if ({16'd0, seg_len} > file_length_q) begin
								rs[1] = mk(jmss_pkg::EV_LENERR, cm, off32(bs), lf, 1'b1);
								n_res = 2'd2;
								fin = 1'b1;
							end else begin
								sk = seg_len;
								ph = (seg_len != '0) ? jmss_pkg::PH_SKIP : jmss_pkg::PH_MARK0;
							end
						end
					end
					jmss_pkg::PH_SKIP: begin
						sk = sk - 16'd1;
						if (sk == '0) begin
							ph = jmss_pkg::PH_MARK0;
						end
					end
					jmss_pkg::PH_EXIF: begin
						if (hmi >= jmss_pkg::EXIF_TAG_LEN || b != jmss_pkg::exif_tag(hmi)) begin
							rs[n_res[0]] = mk(jmss_pkg::EV_OK, cm, off32(bs), lf, 1'b1);
							n_res = n_res + 2'd1;
							fin = 1'b1;
						end else begin
							hmi = hmi + 3'd1;
							if (hmi == jmss_pkg::EXIF_TAG_LEN) begin
								rs[0] = mk(jmss_pkg::EV_EXIF, cm, pos32 + 32'd1, lf - 16'd8, 1'b0);
								rs[1] = mk(jmss_pkg::EV_OK, cm, off32(bs), lf, 1'b1);
								n_res = 2'd2;
								fin = 1'b1;
							end
						end
					end
					jmss_pkg::PH_ENT: begin
						if (b == jmss_pkg::BYTE_FF) begin
							ph = jmss_pkg::PH_ENTFF;
						end
					end
					default: begin
						rs[n_res[0]] = mk(jmss_pkg::EV_INVALID, cm, off32(bs), lf, 1'b1);
						n_res = n_res + 2'd1;
						fin = 1'b1;
					end
				endcase

				if (fin) begin
					ph = jmss_pkg::PH_IDLE;
				end else if (at_end(bs, file_length_q)) begin
					// The byte just consumed was the last one of the file.
					rs[n_res[0]] = mk(jmss_pkg::end_status(ph), cm, off32(bs), lf, 1'b1);
					n_res = n_res + 2'd1;
					fin = 1'b1;
					ph  = jmss_pkg::PH_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= jmss_pkg::PH_IDLE;
			bytes_seen_q   <= '0;
			cur_marker_q   <= '0;
			length_field_q <= '0;
			skip_rem_q     <= '0;
			match_idx_q    <= '0;
			finished_q     <= 1'b1;
		end else if (in_acc) begin
			phase_q        <= ph;
			bytes_seen_q   <= bs;
			cur_marker_q   <= cm;
			length_field_q <= lf;
			skip_rem_q     <= sk;
			match_idx_q    <= hmi;
			finished_q     <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			file_length_q <= cfg_data;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_acc) begin
				wr_ptr_q <= wr_ptr_q + QAW'(n_res);
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (in_acc ? (QAW+1)'(n_res) : '0)
				- (out_acc ? (QAW+1)'(1) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && n_res != 2'd0) begin
			queue_q[wr_ptr_q] <= rs[0];
		end
		if (in_acc && n_res == 2'd2) begin
			queue_q[wr_ptr_q + 1'b1] <= rs[1];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/jmss_checker.sv
// Port-level checker of the JPEG marker segment scanner and its bind.
`default_nettype none

`include "jpeg_marker_segment_scanner_top_assert.svh"

module jmss_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire jmss_pkg::out_item_t out_data
);

	// A stalled result beat stays put.
	`JMSS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))

	// A marker or Exif beat never closes the parse.
	`JMSS_ASSERT_IMP(a_marker_not_last, clk, arst_n, out_valid && out_data.event_res == jmss_pkg::EV_MARKER, !out_data.last)
	`JMSS_ASSERT_IMP(a_exif_not_last, clk, arst_n, out_valid && out_data.event_res == jmss_pkg::EV_EXIF, !out_data.last)

	// The closing beat always carries a status code.
	`JMSS_ASSERT_IMP(a_last_is_status, clk, arst_n, out_valid && out_data.last, out_data.event_res == jmss_pkg::EV_OK || out_data.event_res == jmss_pkg::EV_INVALID || out_data.event_res == jmss_pkg::EV_LENERR)

endmodule

bind jpeg_marker_segment_scanner_top jmss_checker u_jmss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
